[hdl/hvcam_pkg.sv]
`default_nettype none

package hvcam_pkg;

    // status word codes
    localparam logic [31:0] STAT_UNKNOWN = 32'h7FC0_0000;
    localparam int unsigned STALE_BIT = 31;
    localparam logic [31:0] OFF_MISMATCH_SECONDS = 32'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_ALARM_ENABLE = 3'd0;
    localparam logic [2:0] CFG_FAULT_MASK = 3'd1;
    localparam logic [2:0] CFG_CLEAR_AFTER = 3'd2;
    localparam logic [2:0] CFG_LINK_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_ON_STATUS_BIT = 3'd4;

    // configuration reset values
    localparam logic [30:0] RST_FAULT_MASK = 31'h0000_1398;
    localparam logic [30:0] RST_CLEAR_AFTER = 31'd10;
    localparam logic [30:0] RST_LINK_TIMEOUT = 31'd60;
    localparam logic [4:0] RST_ON_STATUS_BIT = 5'd0;

    localparam int unsigned ITEM_W = 147;
    localparam int unsigned IN_TDATA_W = 152;
    localparam int unsigned OUT_TDATA_W = 72;

    // input item, packed so that channel sits in the lowest bits
    typedef struct packed {
        logic [31:0] now_seconds;
        logic        commanded_on;
        logic [31:0] status_word;
        logic [18:0] current_limit;
        logic signed [19:0] current;
        logic        current_valid;
        logic [16:0] voltage_limit;
        logic signed [17:0] voltage;
        logic        voltage_valid;
        logic [5:0]  channel;
    } item_t;

    // result item, over_voltage in the lowest bit
    typedef struct packed {
        logic [31:0] link_dead_seconds;
        logic [1:0]  link_cause;
        logic        link_release;
        logic        link_assert;
        logic        off_mismatch_report;
        logic        alarm_release;
        logic        alarm_assert;
        logic [30:0] fault_bits;
        logic        over_current;
        logic        over_voltage;
    } result_t;

    typedef struct packed {
        logic        alarm_raised;
        logic [31:0] last_fault_second;
        logic [31:0] mismatch_start;
        logic        mismatch_reported;
    } chan_state_t;

    typedef struct packed {
        logic        alarm_enable;
        logic [30:0] fault_mask;
        logic [30:0] clear_after_seconds;
        logic [30:0] link_timeout_seconds;
        logic [4:0]  on_status_bit;
    } cfg_t;

    typedef struct packed {
        logic        over_voltage;
        logic        over_current;
        logic [30:0] fault_bits;
        logic        known;
        logic        stale;
        logic        alarm_assert;
        logic        alarm_release;
        logic        mismatch_report;
    } eval_t;

    typedef struct packed {
        logic        link_assert;
        logic        link_release;
        logic [1:0]  link_cause;
        logic [31:0] link_dead_seconds;
    } link_res_t;

    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_STALE = 2'd1;
    localparam logic [1:0] CAUSE_INVALID = 2'd2;

endpackage

`default_nettype wire

[hdl/hvcam_chan_mem.sv]
`default_nettype none

module hvcam_chan_mem #(
    parameter int DEPTH = 8,
    parameter int AW = 3
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output hvcam_pkg::chan_state_t        rd_data,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire hvcam_pkg::chan_state_t   wr_data
);

    hvcam_pkg::chan_state_t mem [DEPTH];
    hvcam_pkg::chan_state_t rd_data_reg;
    logic [DEPTH-1:0] valid_reg;

    // per-entry valid bits, an unwritten entry reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first read so a following item sees the update of the one before
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/hvcam_chan_eval.sv]
`default_nettype none

module hvcam_chan_eval (
    input  wire hvcam_pkg::item_t       item,
    input  wire logic                   in_range,
    input  wire hvcam_pkg::cfg_t        cfg,
    input  wire hvcam_pkg::chan_state_t cur,
    output hvcam_pkg::chan_state_t      nxt,
    output hvcam_pkg::eval_t            ev
);

    logic        ov;
    logic        oc;
    logic        known;
    logic        usable;
    logic        is_on;
    logic [30:0] fault;
    logic [31:0] mm_start;
    logic [31:0] mm_age;
    logic [31:0] quiet_age;
    logic        mm_hit;

    always_comb
    begin
        ov = item.voltage_valid && (item.voltage > $signed({1'b0, item.voltage_limit}));
        oc = item.current_valid && (item.current > $signed({1'b0, item.current_limit}));
        known = (item.status_word != hvcam_pkg::STAT_UNKNOWN);
        fault = known ? (item.status_word[30:0] & cfg.fault_mask) : '0;
        usable = known && !item.status_word[hvcam_pkg::STALE_BIT];
        is_on = item.status_word[cfg.on_status_bit];

        nxt = cur;
        ev = '0;
        ev.over_voltage = ov;
        ev.over_current = oc;
        ev.fault_bits = fault;
        ev.known = known;
        ev.stale = item.status_word[hvcam_pkg::STALE_BIT];

        // off mismatch episode, a start of zero means none
        mm_start = (cur.mismatch_start == '0) ? item.now_seconds : cur.mismatch_start;
        mm_age = item.now_seconds - mm_start;
        quiet_age = item.now_seconds - cur.last_fault_second;
        mm_hit = !cur.mismatch_reported && (mm_age >= hvcam_pkg::OFF_MISMATCH_SECONDS);

        if (in_range)
        begin
            if (item.commanded_on && usable && !is_on)
            begin
                nxt.mismatch_start = mm_start;
                if (mm_hit)
                begin
                    nxt.mismatch_reported = 1'b1;
                    ev.mismatch_report = 1'b1;
                end
            end
            else
            begin
                nxt.mismatch_start = '0;
                nxt.mismatch_reported = 1'b0;
            end

            if (ov || oc || (fault != '0))
            begin
                nxt.last_fault_second = item.now_seconds;
                nxt.alarm_raised = 1'b1;
                ev.alarm_assert = 1'b1;
            end
            else if (cur.alarm_raised && (quiet_age >= {1'b0, cfg.clear_after_seconds}))
            begin
                nxt.alarm_raised = 1'b0;
                ev.alarm_release = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/hvcam_link.sv]
`default_nettype none

module hvcam_link (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic               scan_last,
    input  wire logic               voltage_valid,
    input  wire logic               known,
    input  wire logic               stale,
    input  wire logic [31:0]        now_seconds,
    input  wire logic [30:0]        link_timeout_seconds,
    output hvcam_pkg::link_res_t    res
);

    logic        all_invalid_reg;
    logic        all_invalid_next;
    logic        all_stale_reg;
    logic        all_stale_next;
    logic [31:0] bad_start_reg;
    logic [31:0] bad_start_next;
    logic        raised_reg;
    logic        raised_next;
    logic        inv_eff;
    logic        stale_eff;
    logic [31:0] start_eff;
    logic [31:0] dead;

    always_comb
    begin
        // summary including this item
        inv_eff = all_invalid_reg && !voltage_valid;
        stale_eff = all_stale_reg && known && stale;
        start_eff = (bad_start_reg == '0) ? now_seconds : bad_start_reg;
        dead = now_seconds - start_eff;

        all_invalid_next = all_invalid_reg;
        all_stale_next = all_stale_reg;
        bad_start_next = bad_start_reg;
        raised_next = raised_reg;
        res = '0;

        if (fire)
        begin
            all_invalid_next = inv_eff;
            all_stale_next = stale_eff;
            if (scan_last)
            begin
                if (stale_eff || inv_eff)
                begin
                    bad_start_next = start_eff;
                    if (dead >= {1'b0, link_timeout_seconds})
                    begin
                        raised_next = 1'b1;
                        res.link_assert = 1'b1;
                        res.link_cause = stale_eff ? hvcam_pkg::CAUSE_STALE
                                                   : hvcam_pkg::CAUSE_INVALID;
                        res.link_dead_seconds = dead;
                    end
                end
                else
                begin
                    bad_start_next = '0;
                    if (raised_reg)
                    begin
                        raised_next = 1'b0;
                        res.link_release = 1'b1;
                    end
                end
                all_invalid_next = 1'b1;
                all_stale_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_invalid_reg <= 1'b1;
            all_stale_reg <= 1'b1;
            bad_start_reg <= '0;
            raised_reg <= 1'b0;
        end
        else
        begin
            all_invalid_reg <= all_invalid_next;
            all_stale_reg <= all_stale_next;
            bad_start_reg <= bad_start_next;
            raised_reg <= raised_next;
        end
    end

`ifndef SYNTH
    a_scan_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && scan_last) |=> (all_invalid_reg && all_stale_reg))
        else $error("scan summary not rearmed after last channel");
`endif

endmodule

`default_nettype wire

[hdl/hv_channel_alarm_monitor_core.sv]
`default_nettype none

// channel     | direction | handshake         | content
// s_*         | in        | s_tvalid/s_tready | one channel reading, tlast = scan_last
// m_*         | out       | m_tvalid/m_tready | one alarm result per reading
// cfg_*       | in        | cfg_we            | register write, no read-back
//
// a reading passes from the input transfer through the evaluation register, where the
// per-channel state is read, into the result register
// sustained rate is one reading per clock while results are taken, set by the write-first per-channel memory
// reset clears all per-channel state at once through valid bits, no clearing pass
// a stalled result holds the evaluation stage; an empty stage still takes a transfer
// with alarm_enable low a reading is taken and dropped, no result, no state change

module hv_channel_alarm_monitor_core #(
    parameter int NUM_CHANNELS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // reading: channel, voltage_valid, voltage, voltage_limit, current_valid,
    // current, current_limit, status_word, commanded_on, now_seconds, zero fill
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [hvcam_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                               s_tlast,
    // result: over_voltage, over_current, fault_bits, alarm_assert, alarm_release,
    // off_mismatch_report, link_assert, link_release, link_cause, link_dead_seconds
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [hvcam_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // configuration write
    input  wire logic                               cfg_we,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [30:0]                        cfg_data
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    hvcam_pkg::cfg_t        cfg_reg;
    hvcam_pkg::item_t       in_item;
    logic                   in_range;
    logic                   accept;

    // evaluation stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    hvcam_pkg::item_t       s1_item_reg;
    logic                   s1_last_reg;
    logic                   s1_range_reg;
    logic                   s1_go;
    logic                   out_fire;

    // result stage
    logic                   m_valid_reg;
    logic                   m_valid_next;
    hvcam_pkg::result_t     res_reg;
    hvcam_pkg::result_t     res_next;

    hvcam_pkg::chan_state_t cur_state;
    hvcam_pkg::chan_state_t nxt_state;
    hvcam_pkg::eval_t       ev;
    hvcam_pkg::link_res_t   link_res;

    assign in_item = hvcam_pkg::item_t'(s_tdata[hvcam_pkg::ITEM_W-1:0]);
    assign in_range = ({1'b0, in_item.channel} < 7'(NUM_CHANNELS));

    // the stage moves on when the result register is free, or when the
    // reading is dropped because alarms are disabled
    assign s1_go = s1_valid_reg && (!m_valid_reg || m_tready || !cfg_reg.alarm_enable);
    assign out_fire = s1_go && cfg_reg.alarm_enable;
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept = s_tvalid && s_tready;

    // per-channel alarm and mismatch state
    hvcam_chan_mem #(
        .DEPTH (NUM_CHANNELS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (in_item.channel[AW-1:0]),
        .rd_data (cur_state),
        .wr_en   (out_fire && s1_range_reg),
        .wr_addr (s1_item_reg.channel[AW-1:0]),
        .wr_data (nxt_state)
    );

    hvcam_chan_eval u_eval (
        .item     (s1_item_reg),
        .in_range (s1_range_reg),
        .cfg      (cfg_reg),
        .cur      (cur_state),
        .nxt      (nxt_state),
        .ev       (ev)
    );

    // scan summary and link alarm
    hvcam_link u_link (
        .clk                  (clk),
        .rst_n                (rst_n),
        .fire                 (out_fire),
        .scan_last            (s1_last_reg),
        .voltage_valid        (s1_item_reg.voltage_valid),
        .known                (ev.known),
        .stale                (ev.stale),
        .now_seconds          (s1_item_reg.now_seconds),
        .link_timeout_seconds (cfg_reg.link_timeout_seconds),
        .res                  (link_res)
    );

    always_comb
    begin
        res_next.over_voltage = ev.over_voltage;
        res_next.over_current = ev.over_current;
        res_next.fault_bits = ev.fault_bits;
        res_next.alarm_assert = ev.alarm_assert;
        res_next.alarm_release = ev.alarm_release;
        res_next.off_mismatch_report = ev.mismatch_report;
        res_next.link_assert = link_res.link_assert;
        res_next.link_release = link_res.link_release;
        res_next.link_cause = link_res.link_cause;
        res_next.link_dead_seconds = link_res.link_dead_seconds;

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (out_fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            cfg_reg.alarm_enable <= 1'b1;
            cfg_reg.fault_mask <= hvcam_pkg::RST_FAULT_MASK;
            cfg_reg.clear_after_seconds <= hvcam_pkg::RST_CLEAR_AFTER;
            cfg_reg.link_timeout_seconds <= hvcam_pkg::RST_LINK_TIMEOUT;
            cfg_reg.on_status_bit <= hvcam_pkg::RST_ON_STATUS_BIT;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hvcam_pkg::CFG_ALARM_ENABLE:  cfg_reg.alarm_enable <= cfg_data[0];
                    hvcam_pkg::CFG_FAULT_MASK:    cfg_reg.fault_mask <= cfg_data;
                    hvcam_pkg::CFG_CLEAR_AFTER:   cfg_reg.clear_after_seconds <= cfg_data;
                    hvcam_pkg::CFG_LINK_TIMEOUT:  cfg_reg.link_timeout_seconds <= cfg_data;
                    hvcam_pkg::CFG_ON_STATUS_BIT: cfg_reg.on_status_bit <= cfg_data[4:0];
                    default:                      ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
            s1_last_reg <= s_tlast;
            s1_range_reg <= in_range;
        end
        if (out_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = res_reg;

`ifndef SYNTH
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> m_valid_reg)
        else $error("evaluated reading did not reach the result register");

    a_alarm_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(res_reg.alarm_assert && res_reg.alarm_release))
        else $error("channel alarm asserted and released together");

    a_cause_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !res_reg.link_assert) |->
            (res_reg.link_cause == hvcam_pkg::CAUSE_NONE))
        else $error("link cause without link assert");
`endif

endmodule

`default_nettype wire
